[src/fdtb_pkg.sv]
// fdtb_pkg: shared types and constants of the fragment depth test and blend block
// holds the stream widths, default store geometry and controller/datapath structs
// no dependencies
package fdtb_pkg;

    // default store geometry
    localparam int FB_WIDTH_DEF   = 256;
    localparam int FB_HEIGHT_DEF  = 256;
    localparam int DEPTH_BITS_DEF = 24;

    // input item fields
    localparam int COORD_W = 8;
    localparam int ZIN_W   = 24;
    localparam int CHAN_W  = 8;

    // stream widths
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;

    // controller to datapath
    typedef struct packed {
        logic cap;      // capture the input item
        logic clr_wr;   // write one clearing entry
        logic rd;       // read both stores
        logic calc;     // depth test and blend products
        logic commit;   // write back and load the result
    } fdtb_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last; // clearing pass at the last entry
        logic out_free; // result register can take a new item
    } fdtb_sts_t;

endpackage

[src/fdtb_ctrl.sv]
// fdtb_ctrl: sequencing state machine of the fragment depth test and blend block
// runs the clearing pass, then one read-test-write pass per item
// depends on fdtb_pkg
module fdtb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output fdtb_pkg::fdtb_cmd_t cmd,
    input  fdtb_pkg::fdtb_sts_t sts
);
    import fdtb_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg, s_tready_next;

    always_comb begin
        state_next    = state_reg;
        s_tready_next = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                if (sts.clr_last) begin
                    state_next    = ST_IDLE;
                    s_tready_next = 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_tvalid && s_tready_reg) begin
                    state_next = ST_READ;
                end else begin
                    s_tready_next = 1'b1;
                end
            end
            ST_READ: begin
                state_next = ST_CALC;
            end
            ST_CALC: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (sts.out_free) begin
                    state_next    = ST_IDLE;
                    s_tready_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            s_tready_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
        end
    end

    assign s_tready   = s_tready_reg;
    assign cmd.cap    = s_tvalid && s_tready_reg;
    assign cmd.clr_wr = (state_reg == ST_CLEAR);
    assign cmd.rd     = (state_reg == ST_READ);
    assign cmd.calc   = (state_reg == ST_CALC);
    assign cmd.commit = (state_reg == ST_COMMIT) && sts.out_free;

    // write-back only when the result register can take it
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> sts.out_free)
        else $error("commit while result register full");

    // a captured item is read from the stores in the next cycle
    a_cap_then_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cap |=> cmd.rd)
        else $error("captured item not read");

    // no item taken during the clearing pass
    a_no_ready_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_wr |-> !s_tready_reg)
        else $error("ready during clearing pass");

    // a stalled result keeps the controller waiting in write-back
    a_commit_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMMIT && !sts.out_free) |=> state_reg == ST_COMMIT)
        else $error("left write-back while result stalled");

endmodule

[src/fdtb_datapath.sv]
// fdtb_datapath: input capture, depth and color stores, depth test, blend and result register
// commanded by fdtb_ctrl through fdtb_cmd_t, reports through fdtb_sts_t
// depends on fdtb_pkg
module fdtb_datapath #(
    parameter int FB_WIDTH   = fdtb_pkg::FB_WIDTH_DEF,
    parameter int FB_HEIGHT  = fdtb_pkg::FB_HEIGHT_DEF,
    parameter int DEPTH_BITS = fdtb_pkg::DEPTH_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  fdtb_pkg::fdtb_cmd_t              cmd,
    output fdtb_pkg::fdtb_sts_t              sts,
    input  logic [fdtb_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [fdtb_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fdtb_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [fdtb_pkg::M_TUSER_W-1:0]   m_tuser
);
    import fdtb_pkg::*;

    localparam int PIXELS = FB_WIDTH * FB_HEIGHT;
    localparam int AW     = $clog2(PIXELS);
    localparam int LIN_W  = AW + 9;
    localparam logic [AW-1:0] CLR_LAST = AW'(PIXELS - 1);
    localparam logic signed [32:0] ZMIN = -(33'sd1 <<< (DEPTH_BITS - 1));
    localparam logic signed [32:0] ZMAX = (33'sd1 <<< (DEPTH_BITS - 1)) - 33'sd1;
    localparam logic [DEPTH_BITS-1:0] DEPTH_CLEAR = {1'b1, {(DEPTH_BITS-1){1'b0}}};

    // floor(v/255) for v below 65280
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = 17'(v) + 17'(v[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    // captured item
    logic [COORD_W-1:0]      x_reg, y_reg;
    logic signed [ZIN_W-1:0] z_reg;
    logic [CHAN_W-1:0]       r_reg, g_reg, b_reg, a_reg;
    logic                    disc_reg;

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            x_reg    <= s_tdata[7:0];
            y_reg    <= s_tdata[15:8];
            z_reg    <= s_tdata[39:16];
            r_reg    <= s_tdata[47:40];
            g_reg    <= s_tdata[55:48];
            b_reg    <= s_tdata[63:56];
            a_reg    <= s_tdata[71:64];
            disc_reg <= s_tuser[0];
        end
    end

    // pixel address and range
    logic [LIN_W-1:0] lin;
    logic [AW-1:0]    addr;
    logic             in_range;

    assign lin      = LIN_W'(x_reg) + LIN_W'(y_reg) * LIN_W'(FB_WIDTH);
    assign addr     = lin[AW-1:0];
    assign in_range = (LIN_W'(x_reg) < LIN_W'(FB_WIDTH)) && (LIN_W'(y_reg) < LIN_W'(FB_HEIGHT));

    // clearing pass counter
    logic [AW-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_wr) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    assign sts.clr_last = (clr_cnt_reg == CLR_LAST);

    // stores
    logic [DEPTH_BITS-1:0]   depth_mem [PIXELS];
    logic [M_TDATA_W-1:0]    color_mem [PIXELS];
    logic signed [DEPTH_BITS-1:0] depth_rd_reg;
    logic [M_TDATA_W-1:0]    color_rd_reg;
    logic [AW-1:0]           addr_reg;
    logic                    range_reg;

    logic                    pass_reg, opaque_reg;
    logic [DEPTH_BITS-1:0]   zsat_reg;
    logic [M_TDATA_W-1:0]    new_col;

    always_ff @(posedge aclk) begin
        if (cmd.clr_wr) begin
            depth_mem[clr_cnt_reg] <= DEPTH_CLEAR;
            color_mem[clr_cnt_reg] <= '0;
        end else if (cmd.commit && pass_reg) begin
            color_mem[addr_reg] <= new_col;
            if (opaque_reg) begin
                depth_mem[addr_reg] <= zsat_reg;
            end
        end
        if (cmd.rd) begin
            depth_rd_reg <= depth_mem[addr];
            color_rd_reg <= color_mem[addr];
            addr_reg     <= addr;
            range_reg    <= in_range;
        end
    end

    // depth saturation and strict test
    logic signed [32:0]           z_wide, z_clamp;
    logic signed [DEPTH_BITS-1:0] zsat;

    always_comb begin
        z_wide = {{(33-ZIN_W){z_reg[ZIN_W-1]}}, z_reg};
        if (z_wide < ZMIN) begin
            z_clamp = ZMIN;
        end else if (z_wide > ZMAX) begin
            z_clamp = ZMAX;
        end else begin
            z_clamp = z_wide;
        end
        zsat = z_clamp[DEPTH_BITS-1:0];
    end

    // blend products, registered before the divide
    logic [15:0] prod_r_reg, prod_g_reg, prod_b_reg;
    logic [15:0] inv_a;

    assign inv_a = 16'(ALPHA_OPAQUE - a_reg);

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            pass_reg   <= range_reg && !disc_reg && (zsat > depth_rd_reg);
            opaque_reg <= (a_reg == ALPHA_OPAQUE);
            zsat_reg   <= zsat;
            prod_r_reg <= 16'(r_reg) * 16'(a_reg) + 16'(color_rd_reg[7:0]) * inv_a;
            prod_g_reg <= 16'(g_reg) * 16'(a_reg) + 16'(color_rd_reg[15:8]) * inv_a;
            prod_b_reg <= 16'(b_reg) * 16'(a_reg) + 16'(color_rd_reg[23:16]) * inv_a;
        end
    end

    always_comb begin
        if (opaque_reg) begin
            new_col = {ALPHA_OPAQUE, b_reg, g_reg, r_reg};
        end else begin
            new_col = {ALPHA_OPAQUE, div255(prod_b_reg), div255(prod_g_reg),
                       div255(prod_r_reg)};
        end
    end

    // result register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TUSER_W-1:0] m_user_reg;

    assign sts.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_user_reg <= {pass_reg && opaque_reg, pass_reg};
            if (!range_reg) begin
                m_data_reg <= '0;
            end else if (pass_reg) begin
                m_data_reg <= new_col;
            end else begin
                m_data_reg <= color_rd_reg;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

[src/fragment_depth_test_blend.sv]
// fragment_depth_test_blend: top level of the per-fragment depth test and blend block
// joins the sequencing controller fdtb_ctrl and the datapath fdtb_datapath
// depends on fdtb_pkg, fdtb_ctrl, fdtb_datapath
//
// Per-fragment output merger with a z-buffer test and alpha blending. Each input
// item is one shaded fragment; each gives exactly one result item. A fragment
// passes when it is not discarded, lies inside the framebuffer and its depth is
// strictly greater than the stored depth (larger is nearer). Opaque fragments
// (alpha 255) write color and depth; translucent ones blend each of r, g, b as
// floor((c*a + d*(255-a))/255), store alpha 255 and keep the old depth. The
// result reports the color now held at the pixel (zero for pixels outside the
// framebuffer) and whether color and depth were written. After reset the block
// clears all FB_WIDTH*FB_HEIGHT entries of both stores (65536 at the default
// size), one entry per cycle; s_tready stays low meanwhile. After that each
// item passes through capture, store read, test and blend products and
// write-back before the next item is accepted, set by the read-modify-write
// through the single read and write port of each store. A finished result
// waits in an output register, so the next item is accepted while m_tready is
// low; the write-back of that item then waits until the earlier result is taken.
module fragment_depth_test_blend #(
    parameter int FB_WIDTH   = fdtb_pkg::FB_WIDTH_DEF,
    parameter int FB_HEIGHT  = fdtb_pkg::FB_HEIGHT_DEF,
    parameter int DEPTH_BITS = fdtb_pkg::DEPTH_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // fragment input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // pixel_x, pixel_y, frag_depth, src_red, src_green, src_blue, src_alpha
    input  logic [fdtb_pkg::S_TDATA_W-1:0] s_tdata,
    // discard_flag
    input  logic [fdtb_pkg::S_TUSER_W-1:0] s_tuser,
    // result output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [fdtb_pkg::M_TDATA_W-1:0] m_tdata,
    // pixel_written, depth_written
    output logic [fdtb_pkg::M_TUSER_W-1:0] m_tuser
);
    import fdtb_pkg::*;

    // command and status between the controller and the datapath
    fdtb_cmd_t cmd;
    fdtb_sts_t sts;

    // sequencing: clearing pass, then capture, read, test, write-back per item
    fdtb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // stores, depth test, blend arithmetic and result register
    fdtb_datapath #(
        .FB_WIDTH   (FB_WIDTH),
        .FB_HEIGHT  (FB_HEIGHT),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
